// ===== rtl/core/pca_pkg.sv =====
// Shared types, widths and register codes for the PID controller with anti-windup.
package pca_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int INTEG_WIDTH    = 40;
   localparam int GAIN_WIDTH     = 16;

   localparam int DIFF_WIDTH  = SAMPLE_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + GAIN_WIDTH;
   // pterm - (gain_deriv * dmeas): one bit for the negation, one for the add
   localparam int PD_WIDTH    = PROD_WIDTH + 2;
   localparam int ISUM_WIDTH  = ((INTEG_WIDTH > PROD_WIDTH) ? INTEG_WIDTH : PROD_WIDTH) + 1;
   localparam int SUM_WIDTH   = ((INTEG_WIDTH > PD_WIDTH) ? INTEG_WIDTH : PD_WIDTH) + 1;
   localparam int LIMQ_WIDTH  = SAMPLE_WIDTH + GAIN_FRAC_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_PROP  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_INTEG = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_DERIV = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE_MIN  = CSR_INDEX_WIDTH'(3);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DRIVE_MAX  = CSR_INDEX_WIDTH'(4);

   localparam logic signed [INTEG_WIDTH-1:0] INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam logic signed [INTEG_WIDTH-1:0] INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_MAX  = 2'd1,
      CLAMP_MIN  = 2'd2
   } clamp_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] target;
      logic signed [SAMPLE_WIDTH-1:0] measured;
      logic                           restart;
   } req_item_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] drive;
      clamp_type                      clamp_state;
   } rsp_item_type;

   // classified item handed from the front to the back
   typedef struct packed {
      logic signed [DIFF_WIDTH-1:0] err;
      logic signed [DIFF_WIDTH-1:0] dmeas;
      logic                         restart;
   } work_type;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0]   gain_prop;
      logic signed [GAIN_WIDTH-1:0]   gain_integ;
      logic signed [GAIN_WIDTH-1:0]   gain_deriv;
      logic signed [SAMPLE_WIDTH-1:0] drive_min;
      logic signed [SAMPLE_WIDTH-1:0] drive_max;
   } csr_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

// ===== rtl/core/pca_front.sv =====
// Front end: accepts items, forms the error and the gated measurement change.
module pca_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pca_pkg::req_item_type req_item,
   input  logic                  queue_full,
   output logic                  push,
   output pca_pkg::work_type     push_data
);

   logic                                  primed_ff;
   logic                                  primed_in;
   logic signed [pca_pkg::SAMPLE_WIDTH-1:0] last_meas_ff;
   logic signed [pca_pkg::SAMPLE_WIDTH-1:0] last_meas_in;
   logic                                  accept;
   logic                                  use_delta;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   // restart drops the first-step flag before this item is used
   assign use_delta = primed_ff && !req_item.restart;

   always_comb begin
      push_data.err     = pca_pkg::DIFF_WIDTH'(req_item.target)
                        - pca_pkg::DIFF_WIDTH'(req_item.measured);
      push_data.restart = req_item.restart;
      if (use_delta) begin
         push_data.dmeas = pca_pkg::DIFF_WIDTH'(req_item.measured)
                         - pca_pkg::DIFF_WIDTH'(last_meas_ff);
      end else begin
         push_data.dmeas = '0;
      end
   end

   always_comb begin
      primed_in    = primed_ff;
      last_meas_in = last_meas_ff;
      if (accept) begin
         primed_in    = 1'b1;
         last_meas_in = req_item.measured;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
      end else begin
         primed_ff <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      last_meas_ff <= last_meas_in;
   end

   assert property (@(posedge clock) disable iff (reset) accept |=> primed_ff)
      else $error("first-step flag not set after an accepted item");

endmodule

// ===== rtl/core/pca_queue.sv =====
// Short item queue between the front end and the back end.
module pca_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pca_pkg::work_type          push_data,
   input  logic                       pop,
   output pca_pkg::queue_status_type  status,
   output pca_pkg::work_type          pop_data
);

   pca_pkg::work_type                  mem_ff [pca_pkg::QUEUE_DEPTH];
   logic [pca_pkg::QPTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pca_pkg::QPTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pca_pkg::QCNT_WIDTH-1:0]     count_ff, count_in;
   logic                               do_push;
   logic                               do_pop;

   localparam logic [pca_pkg::QPTR_WIDTH-1:0] LAST_PTR =
      pca_pkg::QPTR_WIDTH'(pca_pkg::QUEUE_DEPTH - 1);
   localparam logic [pca_pkg::QCNT_WIDTH-1:0] FULL_COUNT =
      pca_pkg::QCNT_WIDTH'(pca_pkg::QUEUE_DEPTH);

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.valid = (count_ff != '0);
   assign pop_data     = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset) !(push && status.full))
      else $error("item pushed into a full queue");

endmodule

// ===== rtl/core/pca_back.sv =====
// Back end: gain products, saturating integrator, clamp and conditional commit.
module pca_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pca_pkg::csr_type           csr,
   input  pca_pkg::queue_status_type  q_status,
   input  pca_pkg::work_type          q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pca_pkg::rsp_item_type      rsp_item
);

   logic advance;

   // product stage
   logic                                     m_valid_ff;
   logic signed [pca_pkg::PROD_WIDTH-1:0]    m_pterm_ff, m_iterm_ff, m_dprod_ff;
   logic signed [pca_pkg::DIFF_WIDTH-1:0]    m_err_ff;
   logic                                     m_restart_ff;

   // combine stage
   logic                                     a_valid_ff;
   logic signed [pca_pkg::PD_WIDTH-1:0]      a_pd_ff;
   logic signed [pca_pkg::PROD_WIDTH-1:0]    a_iterm_ff;
   logic signed [pca_pkg::DIFF_WIDTH-1:0]    a_err_ff;
   logic                                     a_restart_ff;

   // integrator loop and output register
   logic signed [pca_pkg::INTEG_WIDTH-1:0]   integ_ff, integ_in;
   logic                                     rsp_valid_ff, rsp_valid_in;
   pca_pkg::rsp_item_type                    rsp_item_ff, rsp_item_in;

   logic signed [pca_pkg::INTEG_WIDTH-1:0]   integ_base;
   logic signed [pca_pkg::ISUM_WIDTH-1:0]    isum;
   logic signed [pca_pkg::INTEG_WIDTH-1:0]   trial;
   logic signed [pca_pkg::SUM_WIDTH-1:0]     sum;
   logic signed [pca_pkg::SUM_WIDTH-1:0]     sum_shift;
   logic signed [pca_pkg::LIMQ_WIDTH-1:0]    minq, maxq;
   logic                                     commit;
   logic                                     fire;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = q_status.valid && advance;
   assign fire      = advance && a_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
      end else begin
         if (advance) begin
            m_valid_ff <= q_status.valid;
            a_valid_ff <= m_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_pterm_ff   <= pca_pkg::PROD_WIDTH'(csr.gain_prop)
                       * pca_pkg::PROD_WIDTH'(q_data.err);
         m_iterm_ff   <= pca_pkg::PROD_WIDTH'(csr.gain_integ)
                       * pca_pkg::PROD_WIDTH'(q_data.err);
         m_dprod_ff   <= pca_pkg::PROD_WIDTH'(csr.gain_deriv)
                       * pca_pkg::PROD_WIDTH'(q_data.dmeas);
         m_err_ff     <= q_data.err;
         m_restart_ff <= q_data.restart;

         // derivative acts on the measurement, hence the minus sign
         a_pd_ff      <= pca_pkg::PD_WIDTH'(m_pterm_ff) - pca_pkg::PD_WIDTH'(m_dprod_ff);
         a_iterm_ff   <= m_iterm_ff;
         a_err_ff     <= m_err_ff;
         a_restart_ff <= m_restart_ff;
      end
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      integ_base = a_restart_ff ? '0 : integ_ff;
      isum       = pca_pkg::ISUM_WIDTH'(integ_base) + pca_pkg::ISUM_WIDTH'(a_iterm_ff);
      if (isum > pca_pkg::ISUM_WIDTH'(pca_pkg::INTEG_MAX)) begin
         trial = pca_pkg::INTEG_MAX;
      end else if (isum < pca_pkg::ISUM_WIDTH'(pca_pkg::INTEG_MIN)) begin
         trial = pca_pkg::INTEG_MIN;
      end else begin
         trial = isum[pca_pkg::INTEG_WIDTH-1:0];
      end
      sum       = pca_pkg::SUM_WIDTH'(trial) + pca_pkg::SUM_WIDTH'(a_pd_ff);
      sum_shift = sum >>> pca_pkg::GAIN_FRAC_BITS;
      minq      = pca_pkg::LIMQ_WIDTH'(csr.drive_min) <<< pca_pkg::GAIN_FRAC_BITS;
      maxq      = pca_pkg::LIMQ_WIDTH'(csr.drive_max) <<< pca_pkg::GAIN_FRAC_BITS;
   end

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      integ_in     = integ_ff;
      commit       = 1'b0;
      if (advance) begin
         rsp_valid_in = a_valid_ff;
      end
      if (fire) begin
         // max is checked first so crossed limits resolve to max, then min
         if (sum > pca_pkg::SUM_WIDTH'(maxq)) begin
            rsp_item_in.drive       = csr.drive_max;
            rsp_item_in.clamp_state = pca_pkg::CLAMP_MAX;
            commit                  = (a_err_ff <= 0);
         end else if (sum < pca_pkg::SUM_WIDTH'(minq)) begin
            rsp_item_in.drive       = csr.drive_min;
            rsp_item_in.clamp_state = pca_pkg::CLAMP_MIN;
            commit                  = (a_err_ff >= 0);
         end else begin
            rsp_item_in.drive       = sum_shift[pca_pkg::SAMPLE_WIDTH-1:0];
            rsp_item_in.clamp_state = pca_pkg::CLAMP_NONE;
            commit                  = 1'b1;
         end
         integ_in = commit ? trial : integ_base;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !fire |=> $stable(integ_ff))
      else $error("integrator moved without an item in the last stage");

   assert property (@(posedge clock) disable iff (reset) fire |=> rsp_valid_ff)
      else $error("result lost after the last stage fired");

endmodule

// ===== rtl/core/pid_conditional_antiwindup.sv =====
// Top level of the PID controller with conditional-integration anti-windup.
//
// Usage:
//   req_*  : input items (target, measured, restart), taken when req_valid is
//            high and req_stall is low. restart clears the integrator and the
//            first-step flag before the item is processed.
//   rsp_*  : one result per item (drive, clamp_state), taken when rsp_valid
//            is high and rsp_stall is low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write
//            only while no item is in flight.
// Path: an accepted item enters the queue, then passes the product stage,
//   the combine stage and the output register, where its result is shown.
//   Throughput is one item per cycle while no result is stalled, set by the
//   integrator loop (saturating add, output sum, limit compare) around integ_ff.
// Stall: when rsp_stall holds a result, the back end freezes; the two-entry
//   queue absorbs in-flight items and then req_stall rises.
// Reset (synchronous, active high): gains 0, limits at the full sample range,
//   integrator 0, first step pending, queue and pipeline empty.
module pid_conditional_antiwindup (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  pca_pkg::req_item_type                  req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output pca_pkg::rsp_item_type                  rsp_item,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pca_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pca_pkg::GAIN_WIDTH-1:0]         csr_wdata
);

   pca_pkg::csr_type           csr_ff, csr_in;
   pca_pkg::queue_status_type  q_status;
   pca_pkg::work_type          push_data;
   pca_pkg::work_type          pop_data;
   logic                       push;
   logic                       pop;

   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pca_pkg::CSR_GAIN_PROP:  csr_in.gain_prop  = csr_wdata;
            pca_pkg::CSR_GAIN_INTEG: csr_in.gain_integ = csr_wdata;
            pca_pkg::CSR_GAIN_DERIV: csr_in.gain_deriv = csr_wdata;
            pca_pkg::CSR_DRIVE_MIN:  csr_in.drive_min  = csr_wdata[pca_pkg::SAMPLE_WIDTH-1:0];
            pca_pkg::CSR_DRIVE_MAX:  csr_in.drive_max  = csr_wdata[pca_pkg::SAMPLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_prop  <= '0;
         csr_ff.gain_integ <= '0;
         csr_ff.gain_deriv <= '0;
         csr_ff.drive_min  <= pca_pkg::SAMPLE_MIN;
         csr_ff.drive_max  <= pca_pkg::SAMPLE_MAX;
      end else begin
         csr_ff <= csr_in;
      end
   end

   pca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (q_status.full),
      .push       (push),
      .push_data  (push_data)
   );

   pca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (q_status),
      .pop_data  (pop_data)
   );

   pca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_status  (q_status),
      .q_data    (pop_data),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/pid_conditional_antiwindup_tb.sv =====
// Self-checking testbench for the PID controller with conditional anti-windup.
`timescale 1ns / 1ps

module pid_conditional_antiwindup_tb;

   localparam int    SETTLE_CYCLES = 8;
   localparam int    LONG_HOLD     = 64;
   localparam int    RAND_PHASES   = 8;
   localparam int    PHASE_ITEMS   = 112;
   localparam int    REPORT_LIMIT  = 10;
   localparam longint Q_ONE        = longint'(1) << pca_pkg::GAIN_FRAC_BITS;
   localparam logic [pca_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO =
      pca_pkg::CSR_INDEX_WIDTH'(5);
   localparam logic [pca_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI =
      pca_pkg::CSR_INDEX_WIDTH'(7);

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   pca_pkg::req_item_type               req_item  = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   pca_pkg::rsp_item_type               rsp_item;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [pca_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [pca_pkg::GAIN_WIDTH-1:0]      csr_wdata = '0;

   pid_conditional_antiwindup u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // controller shadow state
   pca_pkg::csr_type      ctrl_regs;
   longint                integ_acc;
   longint                meas_hist;
   bit                    primed_flag;
   pca_pkg::rsp_item_type drive_expected[$];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_left  = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_checked = 0;
   int clamp_hits = 0;
   int csr_writes = 0;
   int input_stalls = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("pid_conditional_antiwindup: mismatch");
      $finish;
   end

   function automatic longint integ_sat(longint v);
      if (v > longint'(pca_pkg::INTEG_MAX)) return longint'(pca_pkg::INTEG_MAX);
      if (v < longint'(pca_pkg::INTEG_MIN)) return longint'(pca_pkg::INTEG_MIN);
      return v;
   endfunction

   function automatic pca_pkg::rsp_item_type pid_predict(pca_pkg::req_item_type it);
      longint err, meas, pterm, dterm, trial, sum, minq, maxq, drive;
      pca_pkg::rsp_item_type r;
      if (it.restart) begin
         integ_acc   = 0;
         primed_flag = 1'b0;
      end
      meas  = it.measured;
      err   = longint'(it.target) - meas;
      pterm = longint'(ctrl_regs.gain_prop) * err;
      dterm = 0;
      if (primed_flag) dterm = -(longint'(ctrl_regs.gain_deriv) * (meas - meas_hist));
      meas_hist   = meas;
      primed_flag = 1'b1;
      trial = integ_sat(integ_acc + longint'(ctrl_regs.gain_integ) * err);
      sum   = pterm + trial + dterm;
      minq  = longint'(ctrl_regs.drive_min) * Q_ONE;
      maxq  = longint'(ctrl_regs.drive_max) * Q_ONE;
      if (sum > maxq) begin
         drive = ctrl_regs.drive_max;
         r.clamp_state = pca_pkg::CLAMP_MAX;
         if (err <= 0) integ_acc = trial;
      end else if (sum < minq) begin
         drive = ctrl_regs.drive_min;
         r.clamp_state = pca_pkg::CLAMP_MIN;
         if (err >= 0) integ_acc = trial;
      end else begin
         drive = longint'(ctrl_regs.drive_min)
               + ((sum - minq) >>> pca_pkg::GAIN_FRAC_BITS);
         r.clamp_state = pca_pkg::CLAMP_NONE;
         integ_acc = trial;
      end
      r.drive = drive[pca_pkg::SAMPLE_WIDTH-1:0];
      return r;
   endfunction

   function automatic pca_pkg::req_item_type make_item(int tgt, int meas, bit rs);
      pca_pkg::req_item_type it;
      it.target   = tgt[pca_pkg::SAMPLE_WIDTH-1:0];
      it.measured = meas[pca_pkg::SAMPLE_WIDTH-1:0];
      it.restart  = rs;
      return it;
   endfunction

   function automatic int clip_sample(int v);
      if (v > int'(pca_pkg::SAMPLE_MAX)) return int'(pca_pkg::SAMPLE_MAX);
      if (v < int'(pca_pkg::SAMPLE_MIN)) return int'(pca_pkg::SAMPLE_MIN);
      return v;
   endfunction

   function automatic int rand_sample();
      if ($urandom_range(1)) return int'($urandom_range(4000)) - 2000;
      return int'(shortint'($urandom));
   endfunction

   function automatic logic [pca_pkg::GAIN_WIDTH-1:0] rand_gain();
      case ($urandom_range(3))
         0: return pca_pkg::GAIN_WIDTH'($urandom);
         1: return pca_pkg::GAIN_WIDTH'($urandom_range(1024) - 512);
         2: return pca_pkg::GAIN_WIDTH'($urandom_range(128) - 64);
         default: return $urandom_range(1) ? pca_pkg::SAMPLE_MAX : pca_pkg::SAMPLE_MIN;
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      pca_pkg::rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stalls++;
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (drive_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result drive %0d state %0d", $time,
                           rsp_item.drive, rsp_item.clamp_state);
            end else begin
               want = drive_expected.pop_front();
               if (want.clamp_state != pca_pkg::CLAMP_NONE) clamp_hits++;
               if (rsp_item.drive !== want.drive ||
                   rsp_item.clamp_state !== want.clamp_state) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: expected drive %0d state %0d, got drive %0d state %0d",
                              $time, want.drive, want.clamp_state,
                              rsp_item.drive, rsp_item.clamp_state);
               end
            end
         end
      end
   end

   // receiver: random stalls, or a counted long hold when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // enters and leaves at a falling edge; valid stays high into the next item
   task automatic send_item(pca_pkg::req_item_type it);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      drive_expected.push_back(pid_predict(it));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (drive_expected.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(logic [pca_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [pca_pkg::GAIN_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      case (idx)
         pca_pkg::CSR_GAIN_PROP:  ctrl_regs.gain_prop  = data;
         pca_pkg::CSR_GAIN_INTEG: ctrl_regs.gain_integ = data;
         pca_pkg::CSR_GAIN_DERIV: ctrl_regs.gain_deriv = data;
         pca_pkg::CSR_DRIVE_MIN:  ctrl_regs.drive_min  = data;
         pca_pkg::CSR_DRIVE_MAX:  ctrl_regs.drive_max  = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_all(int kp, int ki, int kd, int lo, int hi);
      wait_idle();
      write_reg(pca_pkg::CSR_GAIN_PROP,  kp[pca_pkg::GAIN_WIDTH-1:0]);
      write_reg(pca_pkg::CSR_GAIN_INTEG, ki[pca_pkg::GAIN_WIDTH-1:0]);
      write_reg(pca_pkg::CSR_GAIN_DERIV, kd[pca_pkg::GAIN_WIDTH-1:0]);
      write_reg(pca_pkg::CSR_DRIVE_MIN,  lo[pca_pkg::GAIN_WIDTH-1:0]);
      write_reg(pca_pkg::CSR_DRIVE_MAX,  hi[pca_pkg::GAIN_WIDTH-1:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_item(make_item(0, 0, 1'b0));
      send_item(make_item(int'(pca_pkg::SAMPLE_MAX), int'(pca_pkg::SAMPLE_MIN), 1'b0));
      send_item(make_item(int'(pca_pkg::SAMPLE_MIN), int'(pca_pkg::SAMPLE_MAX), 1'b1));
   endtask

   task automatic test_gain_extremes();
      write_all(int'(pca_pkg::SAMPLE_MAX), int'(pca_pkg::SAMPLE_MIN),
                int'(pca_pkg::SAMPLE_MAX), int'(pca_pkg::SAMPLE_MIN),
                int'(pca_pkg::SAMPLE_MAX));
      send_item(make_item(int'(pca_pkg::SAMPLE_MAX), int'(pca_pkg::SAMPLE_MIN), 1'b1));
      send_item(make_item(int'(pca_pkg::SAMPLE_MIN), int'(pca_pkg::SAMPLE_MAX), 1'b0));
      send_item(make_item(0, 0, 1'b0));
      send_item(make_item(100, -100, 1'b0));
      write_all(int'(pca_pkg::SAMPLE_MIN), int'(pca_pkg::SAMPLE_MAX),
                int'(pca_pkg::SAMPLE_MIN), int'(pca_pkg::SAMPLE_MIN),
                int'(pca_pkg::SAMPLE_MAX));
      send_item(make_item(int'(pca_pkg::SAMPLE_MIN), int'(pca_pkg::SAMPLE_MAX), 1'b0));
      send_item(make_item(int'(pca_pkg::SAMPLE_MAX), int'(pca_pkg::SAMPLE_MIN), 1'b0));
   endtask

   // derivative kicks drive the sum past a limit with zero error, so the
   // integrator commits; a plain error past a limit must not commit
   task automatic test_antiwindup_commit();
      write_all(256, 128, 256, -100, 100);
      send_item(make_item(1000, 1000, 1'b1));
      send_item(make_item(0, 0, 1'b0));
      send_item(make_item(1000, 1000, 1'b0));
      send_item(make_item(500, 0, 1'b1));
      send_item(make_item(-500, 0, 1'b0));
      send_item(make_item(20, 0, 1'b0));
   endtask

   task automatic test_crossed_limits();
      write_all(256, 0, 0, 50, -50);
      send_item(make_item(100, 0, 1'b1));
      send_item(make_item(0, 0, 1'b0));
      send_item(make_item(-100, 0, 1'b0));
      send_item(make_item(-50, 0, 1'b0));
   endtask

   // writes past the last register must leave every gain and limit alone
   task automatic test_spare_index();
      logic [pca_pkg::CSR_INDEX_WIDTH-1:0] idx;
      write_all(256, 64, 32, -2000, 2000);
      @(negedge clock);
      for (idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI && idx >= CSR_SPARE_LO; idx++)
         write_reg(idx, pca_pkg::GAIN_WIDTH'($urandom));
      csr_valid <= 1'b0;
      send_item(make_item(1234, -77, 1'b0));
   endtask

   // long receiver hold while items keep coming, so the input side backs up
   task automatic test_backpressure();
      int n;
      wait_idle();
      idle_pct  = 0;
      stall_pct = 0;
      hold_left = LONG_HOLD;
      for (n = 0; n < 24; n++)
         send_item(make_item(rand_sample(), rand_sample(), n == 0));
      wait_idle();
   endtask

   task automatic test_random_phase(int count, int idle, int stall);
      int lo, hi, tmp, tgt, meas, left, n;
      bit rs;
      wait_idle();
      lo = rand_sample();
      hi = rand_sample();
      case ($urandom_range(7))
         0: begin lo = int'(pca_pkg::SAMPLE_MIN); hi = int'(pca_pkg::SAMPLE_MAX); end
         1: if (lo < hi) begin tmp = lo; lo = hi; hi = tmp; end
         default: if (lo > hi) begin tmp = lo; lo = hi; hi = tmp; end
      endcase
      write_all(int'(signed'(rand_gain())), int'(signed'(rand_gain())),
                int'(signed'(rand_gain())), lo, hi);
      idle_pct  = idle;
      stall_pct = stall;
      left = 0;
      for (n = 0; n < count; n++) begin
         rs = 1'b0;
         if (left == 0) begin
            left = $urandom_range(40, 5);
            tgt  = rand_sample();
            meas = rand_sample();
            rs   = ($urandom_range(1) != 0);
         end
         if ($urandom_range(99) < 15) begin
            send_item(make_item(int'(shortint'($urandom)), int'(shortint'($urandom)),
                                ($urandom_range(1) != 0)));
         end else begin
            meas = clip_sample(meas + (tgt - meas) / 4 + int'($urandom_range(128)) - 64);
            send_item(make_item(tgt, meas, rs));
         end
         left--;
      end
   endtask

   initial begin
      int p;
      int idle_mode[4]  = '{0, 46, 0, 32};
      int stall_mode[4] = '{0, 0, 46, 32};
      ctrl_regs.gain_prop  = '0;
      ctrl_regs.gain_integ = '0;
      ctrl_regs.gain_deriv = '0;
      ctrl_regs.drive_min  = pca_pkg::SAMPLE_MIN;
      ctrl_regs.drive_max  = pca_pkg::SAMPLE_MAX;
      integ_acc   = 0;
      meas_hist   = 0;
      primed_flag = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_gain_extremes();
      test_antiwindup_commit();
      test_crossed_limits();
      test_spare_index();
      test_backpressure();
      for (p = 0; p < RAND_PHASES; p++)
         test_random_phase(PHASE_ITEMS, idle_mode[p % 4], stall_mode[p % 4]);
      idle_pct  = 0;
      stall_pct = 0;
      wait_idle();

      $display("covered %0d items and %0d results (%0d clamped), %0d register writes,",
               items_sent, results_checked, clamp_hits, csr_writes);
      $display("restart, crossed limits and %0d cycles of input back-pressure",
               input_stalls);
      mismatches += drive_expected.size();
      if (mismatches == 0) begin
         $display("pid_conditional_antiwindup: match");
      end else begin
         $display("pid_conditional_antiwindup: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/pca_pkg.sv
rtl/core/pca_front.sv
rtl/core/pca_queue.sv
rtl/core/pca_back.sv
rtl/core/pid_conditional_antiwindup.sv
bench/pid_conditional_antiwindup_tb.sv
